FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on the rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/ird_pkg.sv
// Shared widths, constants, types and helpers of the IMU rest detector.
package ird_pkg;

    // fraction bits of the magnitude and level values
    localparam int FRAC_BITS = 8;

    localparam int SAMPLE_W  = 16;
    localparam int TIME_W    = 32;
    localparam int WEIGHT_W  = 17;
    localparam int LEVEL_W   = 25;
    localparam int CFG_W     = 32;

    // squares, sum of three squares, root
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int SUMSQ_W   = SQ_W + 2;
    localparam int ROOT_W    = SUMSQ_W / 2 + FRAC_BITS;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SAT_W     = (ROOT_W > LEVEL_W) ? ROOT_W : LEVEL_W;

    // weighting: Q16 weight, product split into hi/lo shift registers
    localparam int Q_SHIFT   = WEIGHT_W - 1;
    localparam int EMA_HI_W  = LEVEL_W + 1;

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX = '1;
    localparam logic [WEIGHT_W-1:0] Q16_ONE   = 17'd65536;

    // step counts of the serial units
    localparam int SQ_STEPS   = SAMPLE_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int EMA_STEPS  = WEIGHT_W;
    localparam int MAX_STEPS  = (ROOT_STEPS > EMA_STEPS) ?
                                ((ROOT_STEPS > SQ_STEPS) ? ROOT_STEPS : SQ_STEPS) :
                                ((EMA_STEPS > SQ_STEPS) ? EMA_STEPS : SQ_STEPS);
    localparam int CNT_W      = $clog2(MAX_STEPS);

    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(SQ_STEPS - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
    localparam logic [CNT_W-1:0] EMA_LAST  = CNT_W'(EMA_STEPS - 1);

    // register reset values
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST      = 17'd13107;
    localparam logic [LEVEL_W-1:0]  ACCEL_LIMIT_RST = 25'd83886;
    localparam logic [LEVEL_W-1:0]  GYRO_LIMIT_RST  = 25'd33536;
    localparam logic [TIME_W-1:0]   HOLD_MS_RST     = 32'd2000;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WEIGHT      = 2'd0,
        REG_ACCEL_LIMIT = 2'd1,
        REG_GYRO_LIMIT  = 2'd2,
        REG_HOLD_MS     = 2'd3
    } cfg_index_t;

    // control of one serial lane
    typedef struct packed {
        logic load;
        logic step;
    } lane_ctrl_t;

    // |cur - prev| of two signed samples; always fits the sample width
    function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] cur,
                                                     input logic [SAMPLE_W-1:0] prev);
        logic [SAMPLE_W:0] d;
        logic [SAMPLE_W:0] mag;
        d   = {cur[SAMPLE_W-1], cur} - {prev[SAMPLE_W-1], prev};
        mag = d[SAMPLE_W] ? (~d + 1'b1) : d;
        return mag[SAMPLE_W-1:0];
    endfunction

endpackage

FILE: rtl/ird_square.sv
// Bit-serial squarer: shift-and-add, one multiplier bit per cycle while step is set.
module ird_square (
    input  logic                                clk,
    input  ird_pkg::lane_ctrl_t                 ctrl,
    input  logic [ird_pkg::SAMPLE_W-1:0]        operand,
    output logic [ird_pkg::SQ_W-1:0]            square
);

    logic [ird_pkg::SAMPLE_W-1:0] mcand_reg;
    logic [ird_pkg::SAMPLE_W-1:0] hi_reg;
    logic [ird_pkg::SAMPLE_W-1:0] lo_reg;
    logic [ird_pkg::SAMPLE_W:0]   sum;

    // partial product add for the current low multiplier bit
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    // lo holds the remaining multiplier bits and collects product bits
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mcand_reg <= operand;
            hi_reg    <= '0;
            lo_reg    <= operand;
        end
        else if (ctrl.step)
        begin
            {hi_reg, lo_reg} <= {sum, lo_reg[ird_pkg::SAMPLE_W-1:1]};
        end
    end

    assign square = {hi_reg, lo_reg};

endmodule

FILE: rtl/ird_sqrt.sv
// Digit-by-digit square root: two radicand bits in, one root bit out per cycle while step is set.
module ird_sqrt (
    input  logic                                clk,
    input  ird_pkg::lane_ctrl_t                 ctrl,
    input  logic [ird_pkg::SUMSQ_W-1:0]         radicand,
    output logic [ird_pkg::LEVEL_W-1:0]         mag
);

    localparam int RadW  = ird_pkg::RAD_W;
    localparam int RemW  = ird_pkg::REM_W;
    localparam int RootW = ird_pkg::ROOT_W;
    localparam int SatW  = ird_pkg::SAT_W;
    localparam int PadW  = 2 * ird_pkg::FRAC_BITS;

    logic [RadW-1:0]  rad_reg;
    logic [RemW-1:0]  rem_reg;
    logic [RootW-1:0] root_reg;
    logic [RemW-1:0]  partial;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  diff;
    logic             fits;
    logic [SatW-1:0]  root_ext;

    // bring down the next bit pair and try root*4+1
    assign partial = {rem_reg[RemW-3:0], rad_reg[RadW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign diff    = partial - trial;
    assign fits    = (partial >= trial);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rad_reg  <= {radicand, {PadW{1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (ctrl.step)
        begin
            rad_reg  <= {rad_reg[RadW-3:0], 2'b00};
            rem_reg  <= fits ? diff : partial;
            root_reg <= {root_reg[RootW-2:0], fits};
        end
    end

    // clamp to the level range
    assign root_ext = SatW'(root_reg);
    assign mag = (root_ext > SatW'(ird_pkg::LEVEL_MAX)) ? ird_pkg::LEVEL_MAX
                                                         : root_ext[ird_pkg::LEVEL_W-1:0];

endmodule

FILE: rtl/ird_ema.sv
// Bit-serial exponential average: w*mag + (1-w)*level over the weight bits.
module ird_ema (
    input  logic                                clk,
    input  ird_pkg::lane_ctrl_t                 ctrl,
    input  logic [ird_pkg::WEIGHT_W-1:0]        weight,
    input  logic [ird_pkg::LEVEL_W-1:0]         mag,
    input  logic [ird_pkg::LEVEL_W-1:0]         level_in,
    output logic [ird_pkg::LEVEL_W-1:0]         level_out
);

    localparam int WeightW = ird_pkg::WEIGHT_W;
    localparam int HiW     = ird_pkg::EMA_HI_W;

    logic [ird_pkg::LEVEL_W-1:0] mag_reg;
    logic [ird_pkg::LEVEL_W-1:0] lvl_reg;
    logic [WeightW-1:0]          wbits_reg;
    logic [WeightW-1:0]          vbits_reg;
    logic [HiW-1:0]              hi_reg;
    logic [WeightW-1:0]          lo_reg;
    logic [WeightW-1:0]          w_clamp;
    logic [HiW:0]                sum;
    logic [HiW+WeightW-1:0]      product;

    // weights above one count as one
    assign w_clamp = (weight > ird_pkg::Q16_ONE) ? ird_pkg::Q16_ONE : weight;

    // both partial products for this bit of w and 1-w
    assign sum = {1'b0, hi_reg}
               + (wbits_reg[0] ? (HiW+1)'(mag_reg) : '0)
               + (vbits_reg[0] ? (HiW+1)'(lvl_reg) : '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mag_reg   <= mag;
            lvl_reg   <= level_in;
            wbits_reg <= w_clamp;
            vbits_reg <= ird_pkg::Q16_ONE - w_clamp;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end
        else if (ctrl.step)
        begin
            wbits_reg        <= {1'b0, wbits_reg[WeightW-1:1]};
            vbits_reg        <= {1'b0, vbits_reg[WeightW-1:1]};
            {hi_reg, lo_reg} <= {sum, lo_reg[WeightW-1:1]};
        end
    end

    // drop the Q16 fraction
    assign product   = {hi_reg, lo_reg};
    assign level_out = product[ird_pkg::Q_SHIFT +: ird_pkg::LEVEL_W];

endmodule

FILE: rtl/imu_rest_detector_unit.sv
// Top level of the IMU rest detector: control sequencer, state and stream ports.
//
// Takes one six-axis sample with a millisecond timestamp per input word, forms
// the Euclidean magnitude of the change against the previous sample for the
// accelerometer and the gyro (Q.8 raw counts), smooths each with a Q16
// exponential average and reports still_now while both levels sit below their
// limits and at_rest once stillness has lasted still_hold_ms. One sample is in
// work at a time: a sample passes through acceptance, bit-serial squaring,
// the sum, the square-root digits, the weighting load, bit-serial weighting,
// the compare and the report before the next acceptance; the first sample
// after reset skips the arithmetic and goes straight to compare and report.
// The square-root digit loop and the serial multipliers take up most of that
// pass. A finished result waits in the output register without stopping the
// next sample; only a result still unread at report time holds the sequencer.
// Configuration writes are always ready.
`include "assert_macros.svh"

module imu_rest_detector_unit (
    input  logic        clk,
    input  logic        rst_n,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 each), time_ms (32)
    input  logic [127:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // at_rest (1), still_now (1), accel_level (25), gyro_level (25), zero pad (4)
    output logic [55:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SampleW = ird_pkg::SAMPLE_W;
    localparam int LevelW  = ird_pkg::LEVEL_W;
    localparam int TimeW   = ird_pkg::TIME_W;
    localparam int TimeLsb = 6 * SampleW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_BLEND_LOAD,
        S_SMOOTH,
        S_COMPARE,
        S_REPORT
    } state_t;

    state_t                         state_reg, state_next;
    logic [ird_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SampleW-1:0]             prev_accel_reg [3];
    logic [SampleW-1:0]             prev_accel_next [3];
    logic [SampleW-1:0]             prev_gyro_reg [3];
    logic [SampleW-1:0]             prev_gyro_next [3];
    logic                           first_reg, first_next;
    logic [LevelW-1:0]              accel_lvl_reg, accel_lvl_next;
    logic [LevelW-1:0]              gyro_lvl_reg, gyro_lvl_next;
    logic                           still_flag_reg, still_flag_next;
    logic [TimeW-1:0]               still_since_reg, still_since_next;
    logic [TimeW-1:0]               now_reg, now_next;
    logic                           below_reg, below_next;
    logic [ird_pkg::WEIGHT_W-1:0]   weight_reg, weight_next;
    logic [LevelW-1:0]              accel_lim_reg, accel_lim_next;
    logic [LevelW-1:0]              gyro_lim_reg, gyro_lim_next;
    logic [TimeW-1:0]               hold_reg, hold_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_rest_reg, out_rest_next;
    logic                           out_still_reg, out_still_next;
    logic [LevelW-1:0]              out_accel_reg, out_accel_next;
    logic [LevelW-1:0]              out_gyro_reg, out_gyro_next;

    logic                           accept;
    logic [SampleW-1:0]             cur_accel [3];
    logic [SampleW-1:0]             cur_gyro [3];
    logic [TimeW-1:0]               cur_time;
    logic [ird_pkg::SQ_W-1:0]       accel_sq [3];
    logic [ird_pkg::SQ_W-1:0]       gyro_sq [3];
    logic [ird_pkg::SUMSQ_W-1:0]    accel_sumsq;
    logic [ird_pkg::SUMSQ_W-1:0]    gyro_sumsq;
    logic [LevelW-1:0]              accel_mag;
    logic [LevelW-1:0]              gyro_mag;
    logic [LevelW-1:0]              accel_blend;
    logic [LevelW-1:0]              gyro_blend;
    logic [LevelW-1:0]              accel_new;
    logic [LevelW-1:0]              gyro_new;
    logic [TimeW-1:0]               elapsed;
    ird_pkg::lane_ctrl_t            sq_ctrl;
    ird_pkg::lane_ctrl_t            root_ctrl;
    ird_pkg::lane_ctrl_t            ema_ctrl;

    // handshakes
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, out_gyro_reg, out_accel_reg, out_still_reg, out_rest_reg};

    // input word unpacking
    assign cur_time = s_tdata[TimeLsb +: TimeW];
    for (genvar i = 0; i < 3; i++)
    begin : g_unpack
        assign cur_accel[i] = s_tdata[i * SampleW +: SampleW];
        assign cur_gyro[i]  = s_tdata[(i + 3) * SampleW +: SampleW];
    end

    // lane controls
    assign sq_ctrl.load   = accept;
    assign sq_ctrl.step   = (state_reg == S_SQUARE);
    assign root_ctrl.load = (state_reg == S_SUM);
    assign root_ctrl.step = (state_reg == S_ROOT);
    assign ema_ctrl.load  = (state_reg == S_BLEND_LOAD);
    assign ema_ctrl.step  = (state_reg == S_SMOOTH);

    // one squarer per axis, fed with |cur - prev|
    for (genvar i = 0; i < 3; i++)
    begin : g_square
        ird_square u_sq_accel (
            .clk     (clk),
            .ctrl    (sq_ctrl),
            .operand (ird_pkg::abs_diff(cur_accel[i], prev_accel_reg[i])),
            .square  (accel_sq[i])
        );
        ird_square u_sq_gyro (
            .clk     (clk),
            .ctrl    (sq_ctrl),
            .operand (ird_pkg::abs_diff(cur_gyro[i], prev_gyro_reg[i])),
            .square  (gyro_sq[i])
        );
    end

    assign accel_sumsq = {2'b00, accel_sq[0]} + {2'b00, accel_sq[1]} + {2'b00, accel_sq[2]};
    assign gyro_sumsq  = {2'b00, gyro_sq[0]} + {2'b00, gyro_sq[1]} + {2'b00, gyro_sq[2]};

    ird_sqrt u_root_accel (
        .clk      (clk),
        .ctrl     (root_ctrl),
        .radicand (accel_sumsq),
        .mag      (accel_mag)
    );

    ird_sqrt u_root_gyro (
        .clk      (clk),
        .ctrl     (root_ctrl),
        .radicand (gyro_sumsq),
        .mag      (gyro_mag)
    );

    ird_ema u_ema_accel (
        .clk       (clk),
        .ctrl      (ema_ctrl),
        .weight    (weight_reg),
        .mag       (accel_mag),
        .level_in  (accel_lvl_reg),
        .level_out (accel_blend)
    );

    ird_ema u_ema_gyro (
        .clk       (clk),
        .ctrl      (ema_ctrl),
        .weight    (weight_reg),
        .mag       (gyro_mag),
        .level_in  (gyro_lvl_reg),
        .level_out (gyro_blend)
    );

    // first sample zeroes both levels
    assign accel_new = first_reg ? '0 : accel_blend;
    assign gyro_new  = first_reg ? '0 : gyro_blend;
    assign elapsed   = now_reg - still_since_reg;

    // sequencer and state update
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        prev_accel_next  = prev_accel_reg;
        prev_gyro_next   = prev_gyro_reg;
        first_next       = first_reg;
        accel_lvl_next   = accel_lvl_reg;
        gyro_lvl_next    = gyro_lvl_reg;
        still_flag_next  = still_flag_reg;
        still_since_next = still_since_reg;
        now_next         = now_reg;
        below_next       = below_reg;
        weight_next      = weight_reg;
        accel_lim_next   = accel_lim_reg;
        gyro_lim_next    = gyro_lim_reg;
        hold_next        = hold_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_rest_next    = out_rest_reg;
        out_still_next   = out_still_reg;
        out_accel_next   = out_accel_reg;
        out_gyro_next    = out_gyro_reg;

        // register writes
        if (cfg_valid)
        begin
            unique case (ird_pkg::cfg_index_t'(cfg_index))
                ird_pkg::REG_WEIGHT:      weight_next    = cfg_data[ird_pkg::WEIGHT_W-1:0];
                ird_pkg::REG_ACCEL_LIMIT: accel_lim_next = cfg_data[LevelW-1:0];
                ird_pkg::REG_GYRO_LIMIT:  gyro_lim_next  = cfg_data[LevelW-1:0];
                ird_pkg::REG_HOLD_MS:     hold_next      = cfg_data[TimeW-1:0];
                default:                  weight_next    = weight_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prev_accel_next = cur_accel;
                    prev_gyro_next  = cur_gyro;
                    now_next        = cur_time;
                    cnt_next        = ird_pkg::SQ_LAST;
                    state_next      = first_reg ? S_COMPARE : S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                if (cnt_reg == '0)
                    state_next = S_SUM;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_SUM:
            begin
                cnt_next   = ird_pkg::ROOT_LAST;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (cnt_reg == '0)
                    state_next = S_BLEND_LOAD;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_BLEND_LOAD:
            begin
                cnt_next   = ird_pkg::EMA_LAST;
                state_next = S_SMOOTH;
            end
            S_SMOOTH:
            begin
                if (cnt_reg == '0)
                    state_next = S_COMPARE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_COMPARE:
            begin
                // stillness test and start-time bookkeeping
                accel_lvl_next = accel_new;
                gyro_lvl_next  = gyro_new;
                first_next     = 1'b0;
                below_next     = (accel_new < accel_lim_reg) && (gyro_new < gyro_lim_reg);
                if ((accel_new < accel_lim_reg) && (gyro_new < gyro_lim_reg))
                begin
                    still_flag_next = 1'b1;
                    if (!still_flag_reg)
                        still_since_next = now_reg;
                end
                else
                begin
                    still_flag_next  = 1'b0;
                    still_since_next = '0;
                end
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                // wait here only while an older result is still unread
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_rest_next  = still_flag_reg && (elapsed >= hold_reg);
                    out_still_next = below_reg;
                    out_accel_next = accel_lvl_reg;
                    out_gyro_next  = gyro_lvl_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            prev_accel_reg  <= '{default: '0};
            prev_gyro_reg   <= '{default: '0};
            first_reg       <= 1'b1;
            accel_lvl_reg   <= '0;
            gyro_lvl_reg    <= '0;
            still_flag_reg  <= 1'b0;
            still_since_reg <= '0;
            below_reg       <= 1'b0;
            weight_reg      <= ird_pkg::WEIGHT_RST;
            accel_lim_reg   <= ird_pkg::ACCEL_LIMIT_RST;
            gyro_lim_reg    <= ird_pkg::GYRO_LIMIT_RST;
            hold_reg        <= ird_pkg::HOLD_MS_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            prev_accel_reg  <= prev_accel_next;
            prev_gyro_reg   <= prev_gyro_next;
            first_reg       <= first_next;
            accel_lvl_reg   <= accel_lvl_next;
            gyro_lvl_reg    <= gyro_lvl_next;
            still_flag_reg  <= still_flag_next;
            still_since_reg <= still_since_next;
            below_reg       <= below_next;
            weight_reg      <= weight_next;
            accel_lim_reg   <= accel_lim_next;
            gyro_lim_reg    <= gyro_lim_next;
            hold_reg        <= hold_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        out_rest_reg  <= out_rest_next;
        out_still_reg <= out_still_next;
        out_accel_reg <= out_accel_next;
        out_gyro_reg  <= out_gyro_next;
    end

    // checks
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !s_tready, "sample taken while busy")
    `ASSERT_IMPLIES(a_since_idle_zero, clk, rst_n, !still_flag_reg, still_since_reg == '0, "start time kept while not still")
    `ASSERT_IMPLIES(a_rest_needs_still, clk, rst_n, out_valid_reg && out_rest_reg, out_still_reg, "at_rest without still_now")

endmodule
